### src/assert_macros.svh
// Assertion macros shared by the owner lookup RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, off while reset is held.
`define BPOL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds.
`define BPOL_NEVER(label, clk, rst_n, cond, msg) \
    `BPOL_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

### src/bpol_pkg.sv
// Package for the block partition owner lookup: sizes, codes and types.
// No dependencies; used by the interfaces, bpol_search and the top level.
`timescale 1ns / 1ps

package bpol_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int MAX_PROCS  = 16;
    localparam int INDEX_BITS = 32;

    localparam int DIM_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int ADDR_W     = DIM_W + SLOT_W;
    localparam int DEPTH      = MAX_DIMS * MAX_PROCS;
    localparam int BOUND_W    = 32;
    localparam int NDIM_W     = 3;
    localparam int PROC_W     = 5;
    localparam int START_W    = 16;
    localparam int OWNER_W    = 17;
    localparam int RANK_W     = MAX_DIMS * SLOT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS   = 3'd0,
        CFG_START_ID   = 3'd1,
        CFG_PROCS_DIM0 = 3'd2,
        CFG_PROCS_DIM1 = 3'd3,
        CFG_PROCS_DIM2 = 3'd4,
        CFG_PROCS_DIM3 = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_func;

    // Effective configuration after range limiting.
    typedef struct packed {
        logic [NDIM_W-1:0]                n_dims;
        logic [START_W-1:0]               start_id;
        logic [MAX_DIMS-1:0][PROC_W-1:0]  procs;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

    typedef struct packed {
        logic                             status;
        logic [OWNER_W-1:0]               owner_id;
        logic [MAX_DIMS-1:0][SLOT_W-1:0]  pos;
    } t_res;

endpackage

### src/bpol_ifs.sv
// Channel interfaces of the owner lookup: request, response and config write.
// Depends on bpol_pkg for field widths.
`timescale 1ns / 1ps

interface bpol_req_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [bpol_pkg::DIM_W-1:0]      wr_dim;
    logic [bpol_pkg::SLOT_W-1:0]     wr_slot;
    logic [bpol_pkg::BOUND_W-1:0]    wr_boundary;
    logic [bpol_pkg::INDEX_BITS-1:0] index0;
    logic [bpol_pkg::INDEX_BITS-1:0] index1;
    logic [bpol_pkg::INDEX_BITS-1:0] index2;
    logic [bpol_pkg::INDEX_BITS-1:0] index3;

    modport source (output valid, func, wr_dim, wr_slot, wr_boundary,
                    index0, index1, index2, index3, input ready);
    modport sink   (input valid, func, wr_dim, wr_slot, wr_boundary,
                    index0, index1, index2, index3, output ready);
endinterface

interface bpol_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bpol_pkg::OWNER_W-1:0] owner_id;
    logic [bpol_pkg::SLOT_W-1:0]  pos0;
    logic [bpol_pkg::SLOT_W-1:0]  pos1;
    logic [bpol_pkg::SLOT_W-1:0]  pos2;
    logic [bpol_pkg::SLOT_W-1:0]  pos3;
    logic                         status;

    modport source (output valid, owner_id, pos0, pos1, pos2, pos3, status,
                    input ready);
    modport sink   (input valid, owner_id, pos0, pos1, pos2, pos3, status,
                    output ready);
endinterface

interface bpol_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bpol_pkg::CFG_IDX_W-1:0]  idx;
    logic [bpol_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

### src/bpol_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bpol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bpol_search.sv
// Lookup sequencer: per-dimension bound check and binary search over the
// boundary RAM, row-major rank accumulation. Depends on bpol_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpol_search (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_start,
    input  logic [bpol_pkg::MAX_DIMS-1:0][bpol_pkg::INDEX_BITS-1:0] i_index,
    input  bpol_pkg::t_cfg                                      i_cfg,
    output logic                                                o_busy,
    output bpol_pkg::t_ram_rd                                   o_rd,
    input  logic [bpol_pkg::BOUND_W-1:0]                        i_rd_data,
    output logic                                                o_res_valid,
    output bpol_pkg::t_res                                      o_res,
    input  logic                                                i_res_ready
);

    localparam int SLOT_W  = bpol_pkg::SLOT_W;
    localparam int DIM_W   = bpol_pkg::DIM_W;
    localparam int RANK_W  = bpol_pkg::RANK_W;
    localparam int PROC_W  = bpol_pkg::PROC_W;
    localparam int PROD_W  = RANK_W + PROC_W;
    localparam int NDIM_W  = bpol_pkg::NDIM_W;
    localparam int OWNER_W = bpol_pkg::OWNER_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BOUND = 5'b00010,
        S_STEP  = 5'b00100,
        S_RANK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                                        r_state, n_state;
    logic [DIM_W-1:0]                              r_dim, n_dim;
    logic [SLOT_W-1:0]                             r_lo, n_lo;
    logic [SLOT_W-1:0]                             r_hi, n_hi;
    logic                                          r_bad, n_bad;
    logic [RANK_W-1:0]                             r_rank, n_rank;
    logic [bpol_pkg::MAX_DIMS-1:0][SLOT_W-1:0]     r_pos, n_pos;
    logic [bpol_pkg::INDEX_BITS-1:0]               r_idx [bpol_pkg::MAX_DIMS];

    logic [bpol_pkg::INDEX_BITS-1:0] w_cur_idx;
    logic [SLOT_W:0]                 w_sum, w_nsum;
    logic [SLOT_W-1:0]               w_mid, w_step_lo, w_step_hi;
    logic [SLOT_W-1:0]               w_last_cur, w_last_next, w_last0;
    logic [DIM_W-1:0]                w_dim_next;
    logic [PROD_W-1:0]               w_prod;

    assign w_cur_idx   = r_idx[r_dim];
    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_sum[SLOT_W:1];
    assign w_dim_next  = DIM_W'(r_dim + 1'b1);
    assign w_last0     = SLOT_W'(i_cfg.procs[0] - PROC_W'(1));
    assign w_last_cur  = SLOT_W'(i_cfg.procs[r_dim] - PROC_W'(1));
    assign w_last_next = SLOT_W'(i_cfg.procs[w_dim_next] - PROC_W'(1));
    assign w_prod      = PROD_W'(r_rank) * PROD_W'(i_cfg.procs[r_dim]);

    // One search step: narrow the range by the entry read at the midpoint.
    always_comb begin
        w_step_lo = r_lo;
        w_step_hi = r_hi;
        if (i_rd_data > w_cur_idx) begin
            w_step_hi = w_mid;
        end else begin
            w_step_lo = SLOT_W'(w_mid + 1'b1);
        end
        w_nsum = {1'b0, w_step_lo} + {1'b0, w_step_hi};
    end

    always_comb begin
        n_state = r_state;
        n_dim   = r_dim;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_bad   = r_bad;
        n_rank  = r_rank;
        n_pos   = r_pos;
        o_rd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_dim   = '0;
                    n_lo    = '0;
                    n_hi    = w_last0;
                    n_bad   = 1'b0;
                    n_rank  = '0;
                    n_pos   = '0;
                    o_rd.en   = 1'b1;
                    o_rd.addr = {DIM_W'(0), w_last0};
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                // Read data holds the last boundary of this dimension.
                if (w_cur_idx >= i_rd_data) begin
                    n_bad   = 1'b1;
                    n_state = S_RANK;
                end else if (r_hi == '0) begin
                    n_state = S_RANK;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = {r_dim, w_mid};
                    n_state   = S_STEP;
                end
            end
            S_STEP: begin
                n_lo = w_step_lo;
                n_hi = w_step_hi;
                if (w_step_hi > w_step_lo) begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = {r_dim, w_nsum[SLOT_W:1]};
                end else begin
                    n_pos[r_dim] = w_step_lo;
                    n_state      = S_RANK;
                end
            end
            S_RANK: begin
                if (r_dim == '0) begin
                    n_rank = RANK_W'(r_pos[r_dim]);
                end else begin
                    n_rank = RANK_W'(w_prod + PROD_W'(r_pos[r_dim]));
                end
                if (NDIM_W'(r_dim) + NDIM_W'(1) == i_cfg.n_dims) begin
                    n_state = S_DONE;
                end else begin
                    n_dim     = w_dim_next;
                    n_lo      = '0;
                    n_hi      = w_last_next;
                    o_rd.en   = 1'b1;
                    o_rd.addr = {w_dim_next, w_last_next};
                    n_state   = S_BOUND;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dim  <= n_dim;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_bad  <= n_bad;
        r_rank <= n_rank;
        r_pos  <= n_pos;
        if (r_state == S_IDLE && i_start) begin
            for (int d = 0; d < bpol_pkg::MAX_DIMS; d++) begin
                r_idx[d] <= i_index[d];
            end
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status = r_bad;
        if (r_bad) begin
            o_res.owner_id = '0;
            o_res.pos      = '0;
        end else begin
            o_res.owner_id = OWNER_W'(i_cfg.start_id) + OWNER_W'(r_rank);
            o_res.pos      = r_pos;
        end
    end

    `BPOL_ASSERT(a_step_range, i_clk, i_rst_n, (r_state == S_STEP) |-> (r_lo < r_hi), "search step with empty range")
    `BPOL_ASSERT(a_step_in_table, i_clk, i_rst_n, (r_state == S_STEP) |-> (r_hi <= w_last_cur), "search range past last slot")
    `BPOL_NEVER(a_idle_read, i_clk, i_rst_n, (r_state == S_IDLE) && !i_start && o_rd.en, "RAM read while idle")
    `BPOL_ASSERT(a_done_hold, i_clk, i_rst_n, (r_state == S_DONE) && !i_res_ready |=> (r_state == S_DONE) && $stable(r_rank), "result lost while stalled")

endmodule

### src/block_partition_owner_lookup.sv
// Block partition owner lookup, top level: channels, config registers,
// boundary RAM and result register. Depends on bpol_pkg, bpol_ifs,
// bpol_ram and bpol_search.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block keeps one table of cumulative part end boundaries per dimension,
// 16 slots each, in a single 64 x 32 synchronous RAM. A write request
// (func 0) stores one boundary and completes in its accept cycle. A lookup
// request (func 1) walks the active dimensions one after another: it reads
// the dimension's last boundary for the range check, then binary-searches
// the table one RAM read per cycle, then folds the position into the
// row-major rank. Each dimension passes through the bound check, any search
// steps and the rank step, and a done state hands the result to the output
// register; the single RAM read port serialises the table reads. One request
// is in flight at a time; the request channel stays ready while a finished
// result waits in the output register.
// Table entries must be written before a lookup reads them. Config writes
// are taken at any time and should only arrive while the block is idle.

module block_partition_owner_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpol_req_if.sink    i_req,
    bpol_rsp_if.source  o_rsp,
    bpol_cfg_if.sink    i_cfg
);

    localparam int MAX_DIMS = bpol_pkg::MAX_DIMS;
    localparam int NDIM_W   = bpol_pkg::NDIM_W;
    localparam int PROC_W   = bpol_pkg::PROC_W;

    // Config registers as written.
    logic [NDIM_W-1:0]               r_num_dims;
    logic [bpol_pkg::START_W-1:0]    r_start_id;
    logic [PROC_W-1:0]               r_procs [MAX_DIMS];

    bpol_pkg::t_cfg                  w_cfg;
    bpol_pkg::t_ram_rd               w_rd;
    bpol_pkg::t_res                  w_res;
    logic [bpol_pkg::BOUND_W-1:0]    w_rd_data;
    logic [MAX_DIMS-1:0][bpol_pkg::INDEX_BITS-1:0] w_index;
    logic                            w_busy;
    logic                            w_res_valid;
    logic                            w_res_ready;
    logic                            w_accept;
    logic                            w_we;
    logic                            w_start;

    // Output register.
    logic                            r_out_valid;
    bpol_pkg::t_res                  r_out;

    // Config port: always ready; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NDIM_W'(1);
            r_start_id <= '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_procs[d] <= PROC_W'(1);
            end
        end else if (i_cfg.valid) begin
            case (bpol_pkg::t_cfg_reg'(i_cfg.idx))
                bpol_pkg::CFG_NUM_DIMS:   r_num_dims <= NDIM_W'(i_cfg.data);
                bpol_pkg::CFG_START_ID:   r_start_id <= i_cfg.data;
                bpol_pkg::CFG_PROCS_DIM0: r_procs[0] <= PROC_W'(i_cfg.data);
                bpol_pkg::CFG_PROCS_DIM1: r_procs[1] <= PROC_W'(i_cfg.data);
                bpol_pkg::CFG_PROCS_DIM2: r_procs[2] <= PROC_W'(i_cfg.data);
                bpol_pkg::CFG_PROCS_DIM3: r_procs[3] <= PROC_W'(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    // Limit the dimension count and process counts to what the table holds; zero counts become one.
    always_comb begin
        w_cfg.start_id = r_start_id;
        if (r_num_dims == '0) begin
            w_cfg.n_dims = NDIM_W'(1);
        end else if (r_num_dims > NDIM_W'(MAX_DIMS)) begin
            w_cfg.n_dims = NDIM_W'(MAX_DIMS);
        end else begin
            w_cfg.n_dims = r_num_dims;
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (r_procs[d] == '0) begin
                w_cfg.procs[d] = PROC_W'(1);
            end else if (r_procs[d] > PROC_W'(bpol_pkg::MAX_PROCS)) begin
                w_cfg.procs[d] = PROC_W'(bpol_pkg::MAX_PROCS);
            end else begin
                w_cfg.procs[d] = r_procs[d];
            end
        end
    end

    // Request side: one lookup in flight; writes go straight to the RAM.
    assign i_req.ready = !w_busy;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_we        = w_accept && (i_req.func == bpol_pkg::FUNC_WRITE);
    assign w_start     = w_accept && (i_req.func == bpol_pkg::FUNC_LOOKUP);

    assign w_index[0] = i_req.index0;
    assign w_index[1] = i_req.index1;
    assign w_index[2] = i_req.index2;
    assign w_index[3] = i_req.index3;

    bpol_ram #(
        .WIDTH (bpol_pkg::BOUND_W),
        .DEPTH (bpol_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({i_req.wr_dim, i_req.wr_slot}),
        .i_wdata (i_req.wr_boundary),
        .i_re    (w_rd.en),
        .i_raddr (w_rd.addr),
        .o_rdata (w_rd_data)
    );

    bpol_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_index     (w_index),
        .i_cfg       (w_cfg),
        .o_busy      (w_busy),
        .o_rd        (w_rd),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // Result register: load when empty or being drained this cycle.
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.owner_id = r_out.owner_id;
    assign o_rsp.pos0     = r_out.pos[0];
    assign o_rsp.pos1     = r_out.pos[1];
    assign o_rsp.pos2     = r_out.pos[2];
    assign o_rsp.pos3     = r_out.pos[3];
    assign o_rsp.status   = r_out.status;

    `BPOL_NEVER(a_rw_overlap, i_clk, i_rst_n, w_we && w_rd.en, "table write during a lookup read")
    `BPOL_ASSERT(a_err_zero, i_clk, i_rst_n, r_out_valid && r_out.status |-> (r_out.owner_id == '0) && (r_out.pos == '0), "error result carries data")
    `BPOL_ASSERT(a_load_busy, i_clk, i_rst_n, w_res_valid |-> w_busy, "result without a lookup in flight")

endmodule
